// ===== sv/rvr_pkg.sv =====
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared types and constants for the RTP video fragment reassembler.
// ----------------------------------------------------------------------------
package rvr_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_BYTES_DEF = 2048;

    localparam logic [31:0] START_MASK   = 32'hffff8000;
    localparam logic [31:0] START_CODE   = 32'h00008000;
    localparam logic [31:0] PICTURE_MASK = 32'hfffffe00;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_PULL  = 1'b1
    } t_cmd;

    // header flags as kept per slot
    typedef struct packed {
        logic mark;
        logic ebit;
        logic sbit;
        logic mode_b;
    } t_flags;

    // one queued item, classified by the front
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] seq;
        logic [15:0] quot;   // seq / slot count
        t_flags      flags;
        logic [2:0]  fmt;
        logic [7:0]  data;
        logic        last;
    } t_item;

endpackage

// ===== sv/rvr_front.sv =====
// ----------------------------------------------------------------------------
// rvr_front
// Command intake: registers the item, works out the slot quotient and queues
// it for the back end in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rvr_front import rvr_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_seq_number,
    input  logic        i_mode_b,
    input  logic        i_start_bits_flag,
    input  logic        i_end_bits_flag,
    input  logic        i_marker,
    input  logic [2:0]  i_source_format,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_packet_last,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_pop
);

    // reciprocal of the slot count, exact for 16-bit dividends
    localparam logic [32:0] Recip =
        33'(((64'd1 << 32) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

    logic        r_in_vld;
    t_item       r_in;
    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        full;
    logic        push;
    logic        accept;
    logic [48:0] prod;
    t_item       pushed;

    assign full   = (r_cnt == 2'd2);
    assign busy   = r_in_vld & full;
    assign accept = start & ~busy;
    assign push   = r_in_vld & ~full;

    assign prod = 49'(r_in.seq) * 49'(Recip);

    always_comb begin
        pushed      = r_in;
        pushed.quot = prod[47:32];
    end

    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (accept) begin
                r_in_vld     <= 1'b1;
                r_in.cmd     <= t_cmd'(i_command);
                r_in.seq     <= i_seq_number;
                r_in.quot    <= '0;
                r_in.flags   <= '{mark: i_marker, ebit: i_end_bits_flag,
                                  sbit: i_start_bits_flag, mode_b: i_mode_b};
                r_in.fmt     <= i_source_format;
                r_in.data    <= i_payload_byte;
                r_in.last    <= i_packet_last;
            end else if (push) begin
                r_in_vld <= 1'b0;
            end
            if (push) begin
                r_q[r_wp] <= pushed;
                r_wp      <= ~r_wp;
            end
            if (i_item_pop && o_item_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_item_pop && o_item_valid);
        end
    end

endmodule

// ===== sv/rvr_back.sv =====
// ----------------------------------------------------------------------------
// rvr_back
// Slot store, unit search and byte drain. Payload lives in one memory with a
// registered read port; slot metadata lives in flops.
// ----------------------------------------------------------------------------
module rvr_back import rvr_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_item_pop,
    output logic       o_done,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_unit_last
);

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int OFF_W     = $clog2(SLOT_BYTES);
    localparam int LEN_W     = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int MEM_DEPTH = SLOT_COUNT << OFF_W;
    localparam logic [SLOT_W-1:0] LastSlot  = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [LEN_W-1:0]  MaxLen    = LEN_W'(SLOT_BYTES);
    localparam logic [15:0]       SlotMul   = 16'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DRAIN, S_READ, S_FIND, S_BACK, S_FWD
    } t_state;

    t_state              r_state;
    t_item               r_cmd;
    logic [SLOT_W-1:0]   r_slot;
    logic [LEN_W-1:0]    r_len [SLOT_COUNT];
    logic [15:0]         r_seq [SLOT_COUNT];
    t_flags              r_flg [SLOT_COUNT];
    logic [3:0][7:0]     r_first [SLOT_COUNT];
    logic [2:0]          r_fmt;
    logic [LEN_W-1:0]    r_fill;
    logic [SLOT_W-1:0]   r_dslot;
    logic [CNT_W-1:0]    r_drem;
    logic [LEN_W-1:0]    r_doff;
    logic                r_held_vld;
    logic [7:0]          r_held;
    logic                r_tried;
    logic [SLOT_W-1:0]   r_fi;
    logic [SLOT_W-1:0]   r_x;
    logic [SLOT_W-1:0]   r_start;
    logic [15:0]         r_exp;
    logic [SLOT_W-1:0]   r_j;
    logic [7:0]          r_mem [MEM_DEPTH];
    logic [7:0]          r_rd;
    logic                r_done;
    logic                r_ovld;
    logic [7:0]          r_obyte;
    logic                r_olast;

    function automatic logic [31:0] word_of(logic [3:0][7:0] fb, logic [LEN_W-1:0] len);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 4; i++) begin
            w = {w[23:0], (LEN_W'(i) < len) ? fb[i] : 8'h00};
        end
        return w;
    endfunction

    function automatic logic has_start(logic [3:0][7:0] fb, logic [LEN_W-1:0] len);
        return (word_of(fb, len) & START_MASK) == START_CODE;
    endfunction

    function automatic logic [SLOT_W-1:0] inc(logic [SLOT_W-1:0] v);
        return (v == LastSlot) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] dec(logic [SLOT_W-1:0] v);
        return (v == '0) ? LastSlot : v - 1'b1;
    endfunction

    // store path
    logic [15:0]       rem16;
    logic [3:0][7:0]   st_first;
    logic              st_we;
    logic [LEN_W-1:0]  st_fill;
    logic              st_pic;
    // drain path
    logic [LEN_W-1:0]  d_len;
    logic [LEN_W-1:0]  d_off1;
    t_flags            d_flg;
    logic [7:0]        d_byte;
    logic              d_hold;
    logic              d_last;
    logic              mem_re;
    logic [SLOT_W+OFF_W-1:0] mem_wa;
    logic [SLOT_W+OFF_W-1:0] mem_ra;
    // search path
    logic              f_skip;
    logic              fw_found;
    logic              fw_miss;
    logic [CNT_W-1:0]  fw_cnt;
    logic              fin;

    assign rem16 = i_item.seq - 16'(i_item.quot * SlotMul);
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;

    always_comb begin
        st_first = r_first[r_slot];
        if (r_fill < LEN_W'(4)) begin
            st_first[r_fill[1:0]] = r_cmd.data;
        end
        st_we   = (r_state == S_EXEC) && (r_cmd.cmd == CMD_STORE) && (r_fill < MaxLen);
        st_fill = (r_fill < MaxLen) ? r_fill + 1'b1 : r_fill;
        st_pic  = (word_of(st_first, st_fill) & PICTURE_MASK) == START_CODE;
    end

    always_comb begin
        d_len  = r_len[r_dslot];
        d_flg  = r_flg[r_dslot];
        d_off1 = r_doff + 1'b1;
        d_byte = r_rd;
        if (r_doff == '0 && d_flg.sbit && r_held_vld) begin
            d_byte = r_rd | r_held;
        end
        d_hold = (d_off1 == d_len) && d_flg.ebit && (r_drem > CNT_W'(1));
        d_last = (r_drem == CNT_W'(1)) && (d_off1 == d_len);
        mem_re = (r_state == S_DRAIN) && (r_drem != '0) && (r_doff < d_len);
        mem_wa = {r_slot, r_fill[OFF_W-1:0]};
        mem_ra = {r_dslot, r_doff[OFF_W-1:0]};
    end

    always_comb begin
        f_skip   = (r_len[r_fi] == '0) ||
                   (r_flg[r_fi].mode_b && !has_start(r_first[r_fi], r_len[r_fi]));
        fw_found = 1'b0;
        fw_miss  = 1'b0;
        fw_cnt   = CNT_W'(r_j);
        if (r_seq[r_x] != r_exp) begin
            fw_miss = 1'b1;
        end else if (r_len[r_x] == '0) begin
            fw_found = (r_j != '0);
            fw_miss  = (r_j == '0);
        end else if (r_j != '0 && has_start(r_first[r_x], r_len[r_x])) begin
            fw_found = 1'b1;
        end else if (!r_flg[r_x].mode_b) begin
            fw_found = 1'b1;
        end else if (r_flg[r_x].mark) begin
            fw_found = 1'b1;
            fw_cnt   = CNT_W'(r_j) + 1'b1;
        end else if (r_j == LastSlot) begin
            fw_miss = 1'b1;
        end
        // result strobe for the pull in progress
        fin = ((r_state == S_DRAIN) && (r_drem == '0) && r_tried) ||
              ((r_state == S_READ) && !d_hold) ||
              ((r_state == S_FIND) && f_skip && (r_fi == LastSlot)) ||
              ((r_state == S_FWD) && !fw_found && fw_miss && (r_fi == LastSlot));
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_mem[mem_wa] <= r_cmd.data;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fmt      <= '0;
            r_fill     <= '0;
            r_dslot    <= '0;
            r_drem     <= '0;
            r_doff     <= '0;
            r_held_vld <= 1'b0;
            r_held     <= '0;
            r_tried    <= 1'b0;
            r_done     <= 1'b0;
            r_ovld     <= 1'b0;
            r_obyte    <= '0;
            r_olast    <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_len[i]   <= '0;
                r_seq[i]   <= '0;
                r_flg[i]   <= '0;
                r_first[i] <= '0;
            end
        end else begin
            r_done <= fin;
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_cmd   <= i_item;
                        r_slot  <= SLOT_W'(rem16);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd.cmd == CMD_STORE) begin
                        r_first[r_slot] <= st_first;
                        if (r_cmd.last) begin
                            r_seq[r_slot] <= r_cmd.seq;
                            r_flg[r_slot] <= r_cmd.flags;
                            r_fill        <= '0;
                            if (r_cmd.fmt != r_fmt && st_pic) begin
                                // new picture format: drop everything
                                r_fmt <= r_cmd.fmt;
                                for (int i = 0; i < SLOT_COUNT; i++) begin
                                    r_len[i] <= '0;
                                end
                                r_drem     <= '0;
                                r_doff     <= '0;
                                r_held_vld <= 1'b0;
                                r_held     <= '0;
                            end else begin
                                r_len[r_slot] <= st_fill;
                            end
                        end else begin
                            r_fill <= st_fill;
                            if (r_fill == '0) begin
                                r_len[r_slot] <= '0;
                            end
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_tried <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_drem == '0) begin
                        r_doff     <= '0;
                        r_held_vld <= 1'b0;
                        r_held     <= '0;
                        if (!r_tried) begin
                            r_fi    <= '0;
                            r_state <= S_FIND;
                        end else begin
                            r_ovld  <= 1'b0;
                            r_obyte <= '0;
                            r_olast <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else if (r_doff >= d_len) begin
                        r_len[r_dslot] <= '0;
                        r_dslot        <= inc(r_dslot);
                        r_drem         <= r_drem - 1'b1;
                        r_doff         <= '0;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (d_last) begin
                        r_doff <= '0;
                    end else begin
                        r_doff <= d_off1;
                    end
                    if (d_hold) begin
                        r_held_vld <= 1'b1;
                        r_held     <= d_byte;
                        r_state    <= S_DRAIN;
                    end else begin
                        r_ovld  <= 1'b1;
                        r_obyte <= d_byte;
                        r_olast <= d_last;
                        if (d_last) begin
                            r_len[r_dslot] <= '0;
                            r_drem         <= '0;
                            r_held_vld     <= 1'b0;
                            r_held         <= '0;
                        end else if (r_doff == '0) begin
                            r_held_vld <= 1'b0;
                            r_held     <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FIND: begin
                    if (f_skip) begin
                        if (r_fi == LastSlot) begin
                            r_ovld  <= 1'b0;
                            r_obyte <= '0;
                            r_olast <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_fi <= r_fi + 1'b1;
                        end
                    end else if (!r_flg[r_fi].mode_b) begin
                        r_dslot <= r_fi;
                        r_drem  <= CNT_W'(1);
                        r_tried <= 1'b1;
                        r_state <= S_DRAIN;
                    end else begin
                        r_start <= r_fi;
                        r_x     <= dec(r_fi);
                        r_exp   <= r_seq[r_fi] - 16'd1;
                        r_state <= S_BACK;
                    end
                end
                S_BACK: begin
                    // walk back to the earliest start code of the run
                    if (!r_flg[r_x].mode_b || r_len[r_x] == '0 || r_seq[r_x] != r_exp) begin
                        r_x     <= r_start;
                        r_exp   <= r_seq[r_start];
                        r_j     <= '0;
                        r_state <= S_FWD;
                    end else begin
                        if (has_start(r_first[r_x], r_len[r_x])) begin
                            r_start <= r_x;
                        end
                        r_x   <= dec(r_x);
                        r_exp <= r_exp - 16'd1;
                    end
                end
                S_FWD: begin
                    if (fw_found) begin
                        r_dslot <= r_start;
                        r_drem  <= fw_cnt;
                        r_tried <= 1'b1;
                        r_state <= S_DRAIN;
                    end else if (fw_miss) begin
                        if (r_fi == LastSlot) begin
                            r_ovld  <= 1'b0;
                            r_obyte <= '0;
                            r_olast <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_fi    <= r_fi + 1'b1;
                            r_state <= S_FIND;
                        end
                    end else begin
                        r_x   <= inc(r_x);
                        r_exp <= r_exp + 16'd1;
                        r_j   <= r_j + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_out_valid = r_ovld;
    assign o_out_byte  = r_obyte;
    assign o_unit_last = r_olast;

endmodule

// ===== sv/rtp_video_fragment_reassembler.sv =====
// ----------------------------------------------------------------------------
// rtp_video_fragment_reassembler
// An accepted transfer is registered in the front and queued in a two-entry FIFO,
// so transfers are taken while the back end works, until busy. The back end takes
// one item at a time: a store passes S_EXEC; a pull with a byte ready passes
// S_EXEC, S_DRAIN and S_READ before o_done is raised, plus an S_DRAIN pass per
// slot passed or edge byte held, and S_FIND, S_BACK, S_FWD while searching slots.
// Reset: synchronous, active low; empties all slots. Results cannot be stalled.
// ----------------------------------------------------------------------------
module rtp_video_fragment_reassembler import rvr_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_seq_number,
    input  logic        i_mode_b,
    input  logic        i_start_bits_flag,
    input  logic        i_end_bits_flag,
    input  logic        i_marker,
    input  logic [2:0]  i_source_format,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_packet_last,
    output logic        o_done,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_unit_last
);

    logic  item_valid;
    t_item item;
    logic  item_pop;

    rvr_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_seq_number     (i_seq_number),
        .i_mode_b         (i_mode_b),
        .i_start_bits_flag(i_start_bits_flag),
        .i_end_bits_flag  (i_end_bits_flag),
        .i_marker         (i_marker),
        .i_source_format  (i_source_format),
        .i_payload_byte   (i_payload_byte),
        .i_packet_last    (i_packet_last),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_item_pop       (item_pop)
    );

    rvr_back #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(item_valid),
        .i_item      (item),
        .o_item_pop  (item_pop),
        .o_done      (o_done),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_unit_last (o_unit_last)
    );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the RTP video fragment reassembler. Packets are stored byte by byte
// and pulls drain reassembled units. A predictor in this module tracks slot
// contents and the active unit, and every result strobe is compared with it.
// ----------------------------------------------------------------------------
module tb_top;
    import rvr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT  = SLOT_COUNT_DEF;
    localparam int NBYTES = SLOT_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_pull_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = CMD_STORE;
    logic [15:0] i_seq_number = '0;
    logic        i_mode_b = 1'b0;
    logic        i_start_bits_flag = 1'b0;
    logic        i_end_bits_flag = 1'b0;
    logic        i_marker = 1'b0;
    logic [2:0]  i_source_format = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        i_packet_last = 1'b0;
    logic        o_done;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_unit_last;

    rtp_video_fragment_reassembler DUT (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  ring_data [NSLOT][NBYTES];
    int          ring_len [NSLOT];
    logic [15:0] ring_seq [NSLOT];
    t_flags      ring_flags [NSLOT];
    logic [2:0]  cur_fmt;
    int          fill_pos;
    int          unit_slot;
    int          unit_left;
    int          unit_pos;
    logic [8:0]  merge_hold;

    t_pull_result pending_pulls[$];
    int  error_count = 0;
    int  burst_left = 0;
    bit  steady_phase = 0;
    logic [2:0] stream_fmt = '0;

    function automatic logic [31:0] head_word(int s);
        logic [31:0] w = '0;
        for (int i = 0; i < 4; i++)
            w = {w[23:0], (i < ring_len[s]) ? ring_data[s][i] : 8'h00};
        return w;
    endfunction

    function automatic bit starts_unit(int s);
        return (head_word(s) & START_MASK) == START_CODE;
    endfunction

    function automatic void close_unit();
        unit_left = 0;
        unit_pos = 0;
        merge_hold = '0;
    endfunction

    function automatic bit locate_unit();
        int first, count, x;
        logic [15:0] sq;
        bit hit;
        for (int i = 0; i < NSLOT; i++) begin
            if (ring_len[i] == 0) continue;
            first = i;
            count = 1;
            if (ring_flags[i].mode_b) begin
                if (!starts_unit(i)) continue;
                sq = ring_seq[i];
                // walk back over the ring looking for the earliest start code
                for (int k = 0; k < NSLOT; k++) begin
                    int j = NSLOT - 1 - k;
                    x = (i + j) % NSLOT;
                    if (!ring_flags[x].mode_b || ring_len[x] == 0) break;
                    if (ring_seq[x] != 16'(sq + j - NSLOT)) break;
                    if (starts_unit(x)) first = x;
                end
                sq = ring_seq[first];
                hit = 0;
                for (int j = 0; j < NSLOT; j++) begin
                    x = (first + j) % NSLOT;
                    if (ring_seq[x] != 16'(sq + j)) break;
                    if (ring_len[x] == 0) begin
                        if (j != 0) begin count = j; hit = 1; end
                        break;
                    end
                    if (j != 0 && starts_unit(x)) begin count = j; hit = 1; break; end
                    if (!ring_flags[x].mode_b) begin count = j; hit = 1; break; end
                    if (ring_flags[x].mark) begin count = j + 1; hit = 1; break; end
                end
                if (!hit) continue;
            end
            unit_slot = first;
            unit_left = count;
            unit_pos = 0;
            merge_hold = '0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit next_unit_byte(output logic [7:0] b, output logic lst);
        int s, n;
        b = '0;
        lst = 0;
        while (unit_left != 0) begin
            s = unit_slot % NSLOT;
            n = ring_len[s];
            if (unit_pos >= n) begin
                ring_len[s] = 0;
                unit_slot = (s + 1) % NSLOT;
                unit_left--;
                unit_pos = 0;
                continue;
            end
            b = ring_data[s][unit_pos];
            if (unit_pos == 0) begin
                if (ring_flags[s].sbit && merge_hold[8]) b |= merge_hold[7:0];
                merge_hold = '0;
            end
            unit_pos++;
            if (unit_pos == n && ring_flags[s].ebit && unit_left > 1) begin
                merge_hold = {1'b1, b};
                continue;
            end
            lst = (unit_left == 1 && unit_pos == n);
            if (lst) begin
                ring_len[s] = 0;
                close_unit();
            end
            return 1;
        end
        close_unit();
        return 0;
    endfunction

    function automatic void predict_store(logic [15:0] sq, t_flags fl, logic [2:0] fmt,
                                          logic [7:0] data, logic lst);
        int s = sq % NSLOT;
        if (fill_pos == 0) ring_len[s] = 0;
        if (fill_pos < NBYTES) begin
            ring_data[s][fill_pos] = data;
            fill_pos++;
        end
        if (!lst) return;
        ring_len[s] = fill_pos;
        ring_seq[s] = sq;
        ring_flags[s] = fl;
        fill_pos = 0;
        if (fmt != cur_fmt && (head_word(s) & PICTURE_MASK) == START_CODE) begin
            cur_fmt = fmt;
            for (int i = 0; i < NSLOT; i++) ring_len[i] = 0;
            close_unit();
        end
    endfunction

    function automatic t_pull_result predict_pull();
        t_pull_result r;
        logic [7:0] b;
        logic l;
        bit ok;
        ok = next_unit_byte(b, l);
        if (!ok && locate_unit()) ok = next_unit_byte(b, l);
        r.valid = ok;
        r.data = ok ? b : 8'h00;
        r.last = ok ? l : 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // sends one item; outside the steady phase, bursts of random length separated by random gaps
    task automatic send_item(t_cmd cmd, logic [15:0] sq, t_flags fl, logic [2:0] fmt,
                             logic [7:0] data, logic lst);
        if (!steady_phase && burst_left == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end else begin
            @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        start = 1'b1;
        i_command = cmd;
        i_seq_number = sq;
        {i_marker, i_end_bits_flag, i_start_bits_flag, i_mode_b} = fl;
        i_source_format = fmt;
        i_payload_byte = data;
        i_packet_last = lst;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_PULL) pending_pulls.push_back(predict_pull());
        else predict_store(sq, fl, fmt, data, lst);
    endtask

    task automatic pull_byte();
        send_item(CMD_PULL, 16'($urandom), t_flags'($urandom), 3'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    // kind: 0 random bytes, 1 picture start code, 2 group start code
    task automatic send_packet(logic [15:0] sq, t_flags fl, logic [2:0] fmt, int kind,
                               int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (kind != 0 && i < 2) b = 8'h00;
            if (kind == 1 && i == 2) b = {7'h40, 1'($urandom)};
            if (kind == 2 && i == 2) b = 8'($urandom_range(8'h82, 8'hff));
            send_item(CMD_STORE, sq, fl, fmt, b, i == n - 1);
        end
    endtask

    // pull until a pull finds nothing ready, then pull four more times
    task automatic drain_all();
        do pull_byte(); while (pending_pulls[$].valid);
        repeat (4) pull_byte();
    endtask

    task automatic test_directed();
        t_flags fl;
        pull_byte();                                    // nothing stored yet
        fl = '{mark: 1'b0, ebit: 1'b1, sbit: 1'b1, mode_b: 1'b0};
        send_packet(16'hffff, fl, stream_fmt, 0, 3);    // mode A unit alone
        pull_byte();
        // mode B chain across seq wrap, shared edge bytes, marker at the end
        send_packet(16'hfffe, '{1'b0, 1'b1, 1'b0, 1'b1}, stream_fmt, 1, 4);
        send_packet(16'hffff, '{1'b0, 1'b1, 1'b1, 1'b1}, stream_fmt, 0, 1);
        send_packet(16'h0000, '{1'b1, 1'b0, 1'b1, 1'b1}, stream_fmt, 0, 2);
        repeat (4) pull_byte();
        // group start ends the chain; format change with picture start flushes
        send_packet(16'h0010, '{1'b0, 1'b0, 1'b0, 1'b1}, stream_fmt, 2, 4);
        stream_fmt = 3'd7;
        send_packet(16'h0020, '{1'b0, 1'b0, 1'b0, 1'b1}, stream_fmt, 1, 4);
        drain_all();
    endtask

    task automatic test_random_streams(int items);
        int sent = 0;
        int chain, n, kind;
        logic [15:0] base;
        t_flags fl;
        while (sent < items) begin
            steady_phase = ($urandom_range(0, 3) == 0);
            base = 16'($urandom);
            if ($urandom_range(0, 9) == 0 && sent > 0)
                stream_fmt = 3'($urandom);
            if ($urandom_range(0, 4) == 0) begin
                // noise: arbitrary flags and contents
                n = $urandom_range(1, 6);
                send_packet(base, t_flags'($urandom), 3'($urandom),
                            $urandom_range(0, 2), n);
                sent += n;
            end else begin
                chain = $urandom_range(1, 5);
                for (int c = 0; c < chain; c++) begin
                    fl.mode_b = ($urandom_range(0, 5) != 0);
                    fl.sbit = 1'($urandom);
                    fl.ebit = 1'($urandom);
                    fl.mark = (c == chain - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
                    kind = (c == 0) ? $urandom_range(1, 2)
                                    : (($urandom_range(0, 7) == 0) ? 2 : 0);
                    n = $urandom_range(kind != 0 ? 4 : 1, 8);
                    // occasionally skip a sequence number to break the chain
                    send_packet(16'(base + c + ($urandom_range(0, 9) == 0)), fl,
                                stream_fmt, kind, n);
                    sent += n;
                    if ($urandom_range(0, 3) == 0) begin pull_byte(); sent++; end
                end
            end
            repeat ($urandom_range(0, 12)) begin pull_byte(); sent++; end
            if ($urandom_range(0, 5) == 0) drain_all();
        end
        steady_phase = 0;
        drain_all();
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_pulls.size() == 0) begin
                report_mismatch("unexpected result", o_out_byte, 0);
            end else begin
                t_pull_result w;
                w = pending_pulls.pop_front();
                if (o_out_valid !== w.valid) report_mismatch("out_valid", o_out_valid, w.valid);
                if (o_out_byte !== w.data) report_mismatch("out_byte", o_out_byte, w.data);
                if (o_unit_last !== w.last) report_mismatch("unit_last", o_unit_last, w.last);
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || pending_pulls.size() == 0 && !start)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            ring_len[i] = 0;
            ring_seq[i] = '0;
            ring_flags[i] = '0;
        end
        cur_fmt = '0;
        fill_pos = 0;
        unit_slot = 0;
        close_unit();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_streams(1200);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_pulls.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
